// ===== hw/rtl/teq_pkg.sv =====
// teq_pkg: shared constants for the timed event queue
// no dependencies
package teq_pkg;

    localparam int DEF_LIVE_DEPTH    = 16;
    localparam int DEF_PENDING_DEPTH = 16;

    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = ID_W + TIME_W;
    localparam int COUNT_W = 5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UPDATE  = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

// ===== hw/rtl/teq_ram.sv =====
// teq_ram: generic single write, single read port ram with registered read
// no dependencies
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/timed_event_queue_top.sv =====
// timed event queue: live event table and pending insert list in two rams
// depends on teq_pkg and teq_ram
// enqueue sweeps both rams, dequeue sweeps the live ram, clear sweeps neither,
// update sweeps the live ram twice, then moves pending entries into free slots found by a scan
// one request at a time; each ram sweep reads one slot per cycle through its single read port
// results are one-cycle strobes, the last one carries last = 1 as busy drops
// asynchronous reset empties the table, the marks and the pending list; ram contents are not cleared
module timed_event_queue_top
    import teq_pkg::*;
#(
    parameter int LIVE_DEPTH    = DEF_LIVE_DEPTH,
    parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [ID_W-1:0]    event_id,
    input  logic [TIME_W-1:0]  start_time,
    input  logic [TIME_W-1:0]  delay,
    input  logic [TIME_W-1:0]  now_time,
    output logic               result_valid,
    output logic               kind,
    output logic [ID_W-1:0]    delivered_id,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] live_count,
    output logic               last
);

    localparam int LAW  = $clog2(LIVE_DEPTH);
    localparam int PAW  = $clog2(PENDING_DEPTH);
    localparam int CW   = $clog2(LIVE_DEPTH + 1);
    localparam int PCW  = $clog2(PENDING_DEPTH + 1);
    localparam int MAXD = (LIVE_DEPTH > PENDING_DEPTH) ? LIVE_DEPTH : PENDING_DEPTH;
    localparam int SW   = $clog2(MAXD + 1);
    localparam int MW   = (CW > PCW) ? CW : PCW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ENQ    = 4'd1;
    localparam logic [3:0] S_DEQ    = 4'd2;
    localparam logic [3:0] S_EXP    = 4'd3;
    localparam logic [3:0] S_DLV    = 4'd4;
    localparam logic [3:0] S_INS_RD = 4'd5;
    localparam logic [3:0] S_INS_WR = 4'd6;
    localparam logic [3:0] S_MARKS  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [TIME_W-1:0]     exp_reg, exp_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [LIVE_DEPTH-1:0] valid_reg, valid_next;
    logic [LIVE_DEPTH-1:0] mark_reg, mark_next;
    logic [LIVE_DEPTH-1:0] xmask_reg, xmask_next;
    logic [PCW-1:0]        pend_reg, pend_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         upd_cnt_reg, upd_cnt_next;
    logic [CW-1:0]         kept_reg, kept_next;
    logic [CW-1:0]         free_reg, free_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         didx_reg, didx_next;
    logic                  dvld_reg, dvld_next;
    logic                  dup_reg, dup_next;
    logic [1:0]            st_reg, st_next;
    logic [LAW:0]          slot_reg, slot_next;
    logic [PCW-1:0]        pidx_reg, pidx_next;

    logic                  rv_reg, rv_next;
    logic                  kind_reg, kind_next;
    logic [ID_W-1:0]       did_reg, did_next;
    logic [1:0]            rst_reg, rst_next;
    logic [COUNT_W-1:0]    lc_reg, lc_next;
    logic                  last_reg, last_next;

    logic                  l_we, l_re, p_we, p_re;
    logic [LAW-1:0]        l_waddr, l_raddr;
    logic [PAW-1:0]        p_waddr, p_raddr;
    logic [ENTRY_W-1:0]    l_wdata, l_rdata, p_wdata, p_rdata;

    logic [TIME_W:0]       sum;
    logic [LAW-1:0]        dslot;
    logic [LAW-1:0]        islot;
    logic [MW-1:0]         pend_w, free_w, take_w;
    logic [SW-1:0]         scan_end;

    teq_ram #(.WIDTH(ENTRY_W), .DEPTH(LIVE_DEPTH)) u_live_ram (
        .clk     (clk),
        .wr_en   (l_we),
        .wr_addr (l_waddr),
        .wr_data (l_wdata),
        .rd_en   (l_re),
        .rd_addr (l_raddr),
        .rd_data (l_rdata)
    );

    teq_ram #(.WIDTH(ENTRY_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_waddr),
        .wr_data (p_wdata),
        .rd_en   (p_re),
        .rd_addr (p_raddr),
        .rd_data (p_rdata)
    );

    assign sum    = {1'b0, start_time} + {1'b0, delay};
    assign dslot  = didx_reg[LAW-1:0];
    assign islot  = slot_reg[LAW-1:0];
    assign pend_w = MW'(pend_reg);
    assign free_w = MW'(free_reg);
    assign take_w = (pend_w > free_w) ? free_w : pend_w;

    always_comb
    begin
        state_next   = state_reg;
        id_next      = id_reg;
        exp_next     = exp_reg;
        now_next     = now_reg;
        valid_next   = valid_reg;
        mark_next    = mark_reg;
        xmask_next   = xmask_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        upd_cnt_next = upd_cnt_reg;
        kept_next    = kept_reg;
        free_next    = free_reg;
        idx_next     = idx_reg;
        didx_next    = didx_reg;
        dvld_next    = 1'b0;
        dup_next     = dup_reg;
        st_next      = st_reg;
        slot_next    = slot_reg;
        pidx_next    = pidx_reg;
        rv_next      = 1'b0;
        kind_next    = kind_reg;
        did_next     = did_reg;
        rst_next     = rst_reg;
        lc_next      = lc_reg;
        last_next    = last_reg;
        l_we         = 1'b0;
        l_waddr      = islot;
        l_wdata      = p_rdata;
        l_re         = 1'b0;
        l_raddr      = idx_reg[LAW-1:0];
        p_we         = 1'b0;
        p_waddr      = pend_reg[PAW-1:0];
        p_wdata      = {exp_reg, id_reg};
        p_re         = 1'b0;
        p_raddr      = idx_reg[PAW-1:0];
        scan_end     = (state_reg == S_ENQ) ? SW'(MAXD) : SW'(LIVE_DEPTH);

        // sweep: issue one read per cycle, handle the data read the cycle before
        if (state_reg == S_ENQ || state_reg == S_DEQ || state_reg == S_EXP ||
            state_reg == S_DLV)
        begin
            if (idx_reg < scan_end)
            begin
                l_re      = (idx_reg < SW'(LIVE_DEPTH));
                p_re      = (state_reg == S_ENQ) && (idx_reg < SW'(PENDING_DEPTH));
                dvld_next = 1'b1;
                didx_next = idx_reg;
                idx_next  = idx_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next   = event_id;
                    exp_next  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    now_next  = now_time;
                    idx_next  = '0;
                    dup_next  = 1'b0;
                    st_next   = ST_DONE;
                    kept_next = '0;
                    free_next = '0;
                    unique case (op)
                        OP_ENQUEUE: state_next = S_ENQ;
                        OP_DEQUEUE: state_next = S_DEQ;
                        OP_CLEAR:   state_next = S_FIN;
                        OP_UPDATE:  state_next = S_EXP;
                        default:    state_next = S_IDLE;
                    endcase
                    if (op == OP_CLEAR)
                    begin
                        mark_next = mark_reg | valid_reg;
                        pend_next = '0;
                    end
                end
            end
            S_ENQ:
            begin
                if (dvld_reg)
                begin
                    if (didx_reg < SW'(LIVE_DEPTH) && valid_reg[dslot] &&
                        l_rdata[ID_W-1:0] == id_reg)
                    begin
                        dup_next = 1'b1;
                    end
                    if (didx_reg < SW'(pend_reg) && p_rdata[ID_W-1:0] == id_reg)
                    begin
                        dup_next = 1'b1;
                    end
                end
                else if (idx_reg == scan_end)
                begin
                    state_next = S_FIN;
                    if (dup_reg)
                    begin
                        st_next = ST_DUP;
                    end
                    else if (pend_reg == PCW'(PENDING_DEPTH))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        p_we      = 1'b1;
                        pend_next = pend_reg + 1'b1;
                    end
                end
            end
            S_DEQ:
            begin
                if (dvld_reg)
                begin
                    if (valid_reg[dslot] && l_rdata[ID_W-1:0] == id_reg)
                    begin
                        mark_next[dslot] = 1'b1;
                    end
                end
                else if (idx_reg == scan_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_EXP:
            begin
                if (dvld_reg)
                begin
                    xmask_next[dslot] = valid_reg[dslot] &&
                                        (l_rdata[ENTRY_W-1:ID_W] <= now_reg);
                    if (!valid_reg[dslot] || l_rdata[ENTRY_W-1:ID_W] <= now_reg)
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    else if (!mark_reg[dslot])
                    begin
                        kept_next = kept_reg + 1'b1;
                    end
                end
                else if (idx_reg == scan_end)
                begin
                    // final count is known before any delivery goes out
                    upd_cnt_next = kept_reg + CW'(take_w);
                    if (pend_w > free_w)
                    begin
                        st_next = ST_FULL;
                    end
                    idx_next   = '0;
                    state_next = S_DLV;
                end
            end
            S_DLV:
            begin
                if (dvld_reg)
                begin
                    if (xmask_reg[dslot])
                    begin
                        rv_next   = 1'b1;
                        kind_next = KIND_DELIVER;
                        did_next  = l_rdata[ID_W-1:0];
                        rst_next  = ST_DONE;
                        lc_next   = COUNT_W'(upd_cnt_reg);
                        last_next = 1'b0;
                    end
                end
                else if (idx_reg == scan_end)
                begin
                    valid_next = valid_reg & ~xmask_reg;
                    mark_next  = mark_reg & ~xmask_reg;
                    slot_next  = '0;
                    pidx_next  = '0;
                    state_next = (pend_reg == '0) ? S_MARKS : S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                p_re       = 1'b1;
                p_raddr    = pidx_reg[PAW-1:0];
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                // walk to the next free slot, pending entry held on the ram output
                if (slot_reg == (LAW+1)'(LIVE_DEPTH))
                begin
                    state_next = S_MARKS;
                end
                else if (valid_reg[islot])
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    l_we              = 1'b1;
                    valid_next[islot] = 1'b1;
                    mark_next[islot]  = 1'b0;
                    slot_next         = slot_reg + 1'b1;
                    pidx_next         = pidx_reg + 1'b1;
                    state_next        = (pidx_reg + 1'b1 == pend_reg) ? S_MARKS : S_INS_RD;
                end
            end
            S_MARKS:
            begin
                valid_next = valid_reg & ~mark_reg;
                mark_next  = '0;
                pend_next  = '0;
                cnt_next   = upd_cnt_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                rv_next    = 1'b1;
                kind_next  = KIND_STATUS;
                did_next   = '0;
                rst_next   = st_reg;
                lc_next    = COUNT_W'(cnt_reg);
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            mark_reg  <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            dvld_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            dvld_reg  <= dvld_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        exp_reg     <= exp_next;
        now_reg     <= now_next;
        xmask_reg   <= xmask_next;
        upd_cnt_reg <= upd_cnt_next;
        kept_reg    <= kept_next;
        free_reg    <= free_next;
        idx_reg     <= idx_next;
        didx_reg    <= didx_next;
        dup_reg     <= dup_next;
        st_reg      <= st_next;
        slot_reg    <= slot_next;
        pidx_reg    <= pidx_next;
        kind_reg    <= kind_next;
        did_reg     <= did_next;
        rst_reg     <= rst_next;
        lc_reg      <= lc_next;
        last_reg    <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign delivered_id = did_reg;
    assign status       = rst_reg;
    assign live_count   = lc_reg;
    assign last         = last_reg;

endmodule

// ===== hw/rtl/teq_checker.sv =====
// teq_sva: port-level checks for the timed event queue
// depends on teq_pkg; bound to timed_event_queue_top
module teq_sva
    import teq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input logic               kind,
    input logic [1:0]         status,
    input logic [ID_W-1:0]    delivered_id,
    input logic               last
);

    // the status result ends the request and frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("busy after final result");

    // deliveries only appear while the request is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("delivery outside a request");

    // final result and status kind go together
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == (kind == KIND_STATUS)))
        else $error("last and kind disagree");

    // deliveries carry no status, status results carry no id
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((kind == KIND_DELIVER && status == ST_DONE) ||
                          (kind == KIND_STATUS && delivered_id == '0)))
        else $error("result fields inconsistent with kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

endmodule

bind timed_event_queue_top teq_sva u_teq_sva (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .status       (status),
    .delivered_id (delivered_id),
    .last         (last)
);
